// File: rtl/kp200_pkg.sv
// Shared types, constants and helper functions for the Keccak-p[200] permutation.
// No dependencies; used by kp200_round and keccak_p200_permutation.
`default_nettype none
package kp200_pkg;

  localparam int unsigned LaneCount   = 25;
  localparam int unsigned LaneW       = 8;
  localparam int unsigned RoundCntW   = 5;
  localparam int unsigned MaxRoundsDef = 18;
  localparam logic [RoundCntW-1:0] RoundCountRst = 5'd18;

  // Full 25-lane state, lane x+5y at index x+5y.
  typedef logic [LaneCount-1:0][LaneW-1:0] lanes_t;

  // Iota round constants, index 0 upward; unused codes give zero.
  function automatic logic [LaneW-1:0] round_const(input logic [RoundCntW-1:0] idx);
    logic [LaneW-1:0] rc;
    case (idx)
      5'd0:    rc = 8'h01;
      5'd1:    rc = 8'h82;
      5'd2:    rc = 8'h8a;
      5'd3:    rc = 8'h00;
      5'd4:    rc = 8'h8b;
      5'd5:    rc = 8'h01;
      5'd6:    rc = 8'h81;
      5'd7:    rc = 8'h09;
      5'd8:    rc = 8'h8a;
      5'd9:    rc = 8'h88;
      5'd10:   rc = 8'h09;
      5'd11:   rc = 8'h0a;
      5'd12:   rc = 8'h8b;
      5'd13:   rc = 8'h8b;
      5'd14:   rc = 8'h89;
      5'd15:   rc = 8'h03;
      5'd16:   rc = 8'h02;
      5'd17:   rc = 8'h80;
      default: rc = 8'h00;
    endcase
    return rc;
  endfunction

  // Rho rotation offsets per lane (mod 8).
  function automatic int unsigned rho_offset(input int unsigned lane);
    int unsigned r;
    case (lane)
      0: r = 0;  1: r = 1;  2: r = 6;  3: r = 4;  4: r = 3;
      5: r = 4;  6: r = 4;  7: r = 6;  8: r = 7;  9: r = 4;
      10: r = 3; 11: r = 2; 12: r = 3; 13: r = 1; 14: r = 7;
      15: r = 1; 16: r = 5; 17: r = 7; 18: r = 5; 19: r = 0;
      20: r = 2; 21: r = 2; 22: r = 5; 23: r = 0; 24: r = 6;
      default: r = 0;
    endcase
    return r;
  endfunction

  // Rotate a lane left by a constant amount.
  function automatic logic [LaneW-1:0] rotl8(input logic [LaneW-1:0] v,
                                            input int unsigned n);
    logic [2*LaneW-1:0] dbl;
    logic [2*LaneW-1:0] sh;
    dbl = {v, v};
    sh  = dbl >> (LaneW - (n % LaneW));
    return sh[LaneW-1:0];
  endfunction

endpackage
`default_nettype wire

// File: rtl/kp200_round.sv
// One Keccak-p[200] round: theta, rho, pi, chi, iota.
// Depends on kp200_pkg.
`default_nettype none
module kp200_round (
  input  kp200_pkg::lanes_t                    lanes_i,
  input  logic [kp200_pkg::RoundCntW-1:0]      rnd_i,
  output kp200_pkg::lanes_t                    lanes_o
);
  import kp200_pkg::*;

  logic [4:0][LaneW-1:0] col;
  logic [4:0][LaneW-1:0] dif;
  lanes_t                theta;
  lanes_t                pi_out;
  lanes_t                chi_out;

  always_comb begin
    for (int x = 0; x < 5; x++) begin
      col[x] = lanes_i[x] ^ lanes_i[x+5] ^ lanes_i[x+10] ^ lanes_i[x+15] ^ lanes_i[x+20];
    end
    for (int x = 0; x < 5; x++) begin
      dif[x] = rotl8(col[(x+1)%5], 1) ^ col[(x+4)%5];
    end
    for (int x = 0; x < 5; x++) begin
      for (int y = 0; y < 5; y++) begin
        theta[x+5*y] = lanes_i[x+5*y] ^ dif[x];
      end
    end
    // rho + pi: lane (x,y) moves to (y, 2x+3y)
    for (int x = 0; x < 5; x++) begin
      for (int y = 0; y < 5; y++) begin
        pi_out[y + 5*((2*x + 3*y) % 5)] = rotl8(theta[x+5*y], rho_offset(x+5*y));
      end
    end
    for (int y = 0; y < 5; y++) begin
      for (int x = 0; x < 5; x++) begin
        chi_out[x+5*y] = pi_out[x+5*y] ^
                         (~pi_out[((x+1)%5)+5*y] & pi_out[((x+2)%5)+5*y]);
      end
    end
    lanes_o    = chi_out;
    lanes_o[0] = chi_out[0] ^ round_const(rnd_i);
  end

endmodule
`default_nettype wire

// File: rtl/keccak_p200_permutation.sv
// Keccak-p[200] permutation, iterative: one shared round unit, one round per cycle.
// Per transaction: round_count (saturated at MAX_ROUNDS) sets the limit; limit rounds
// pass through the round unit, a last run step finishes, and the done strobe is registered.
// A new transaction is accepted only while idle (busy_o low); busy_o is high in the run state.
// Reset (rst_ni low, async): idle, no strobe, round_count back to 18. State lanes unreset.
// Results are valid only in the done_o cycle; the receiver cannot stall.
`default_nettype none
module keccak_p200_permutation #(
  parameter int unsigned MAX_ROUNDS = kp200_pkg::MaxRoundsDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // command channel
  input  logic                              start_i,
  output logic                              busy_o,
  input  logic [63:0]                       state_word_a_i,
  input  logic [63:0]                       state_word_b_i,
  input  logic [63:0]                       state_word_c_i,
  input  logic [7:0]                        state_last_lane_i,
  // result strobe
  output logic                              done_o,
  output logic [63:0]                       result_word_a_o,
  output logic [63:0]                       result_word_b_o,
  output logic [63:0]                       result_word_c_o,
  output logic [7:0]                        result_last_lane_o,
  // configuration write channel (round_count)
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [kp200_pkg::RoundCntW-1:0]   cfg_round_count_i
);
  import kp200_pkg::*;

  // Round counter only needs to reach the saturated limit.
  localparam int unsigned RndW = (MAX_ROUNDS < 2) ? 1 : $clog2(MAX_ROUNDS + 1);

  typedef enum logic {StIdle, StRun} state_e;

  state_e                state_q, state_d;
  logic                  done_q, done_d;
  logic [RndW-1:0]       rnd_q, rnd_d;
  logic [RndW-1:0]       limit_q, limit_d;
  logic [RoundCntW-1:0]  round_count_q;
  lanes_t                lanes_q, lanes_d;
  lanes_t                round_out;
  logic                  start_acc;

  assign start_acc   = start_i && (state_q == StIdle);
  assign cfg_ready_o = 1'b1;

  // Config register; the host must write only while idle; the block itself does not enforce this.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      round_count_q <= RoundCountRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      round_count_q <= cfg_round_count_i;
    end
  end

  // Shared round datapath
  kp200_round u_round (
    .lanes_i (lanes_q),
    .rnd_i   (RoundCntW'(rnd_q)),
    .lanes_o (round_out)
  );

  always_comb begin
    state_d = state_q;
    done_d  = 1'b0;
    rnd_d   = rnd_q;
    limit_d = limit_q;
    lanes_d = lanes_q;
    case (state_q)
      StIdle: begin
        if (start_acc) begin
          lanes_d[7:0]   = state_word_a_i;
          lanes_d[15:8]  = state_word_b_i;
          lanes_d[23:16] = state_word_c_i;
          lanes_d[24]    = state_last_lane_i;
          rnd_d          = '0;
          // saturate the configured count
          if (round_count_q > RoundCntW'(MAX_ROUNDS)) begin
            limit_d = RndW'(MAX_ROUNDS);
          end else begin
            limit_d = RndW'(round_count_q);
          end
          state_d = StRun;
        end
      end
      StRun: begin
        if (rnd_q == limit_q) begin
          done_d  = 1'b1;
          rnd_d   = '0;
          state_d = StIdle;
        end else begin
          lanes_d = round_out;
          rnd_d   = rnd_q + 1'b1;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      done_q  <= 1'b0;
      rnd_q   <= '0;
      limit_q <= '0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
      rnd_q   <= rnd_d;
      limit_q <= limit_d;
    end
  end

  // State lanes: payload, no reset
  always_ff @(posedge clk_i) begin
    lanes_q <= lanes_d;
  end

  assign busy_o             = (state_q == StRun);
  assign done_o             = done_q;
  // lanes hold during the strobe cycle since the block is idle then
  assign result_word_a_o    = lanes_q[7:0];
  assign result_word_b_o    = lanes_q[15:8];
  assign result_word_c_o    = lanes_q[23:16];
  assign result_last_lane_o = lanes_q[24];

`ifndef SYNTHESIS
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o)
    else $error("done strobe while busy");

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("accepted transaction did not start");

  a_rnd_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o |-> (rnd_q <= limit_q))
    else $error("round index past limit");

  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("repeated done strobe");
`endif

endmodule
`default_nettype wire
